>>> design/two_key_sorted_priority_queue_defines.svh
// Assertion macros for the two-key sorted priority queue checker.
// No dependencies; included by the checker file.
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TKSQ_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tksq checker: same-cycle check failed");

// next-cycle implication, disabled during reset
`define TKSQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tksq checker: next-cycle check failed");

`endif

>>> design/tksq_pkg.sv
// Shared types and codes for the two-key sorted priority queue.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package tksq_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int CLASS_W = 4;
    localparam int DUR_W   = 24;
    localparam int TAG_W   = 16;
    localparam int OCC_W   = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [DUR_W-1:0]   dur;
        logic [CLASS_W-1:0] cls;
    } entry_t;

endpackage

>>> design/two_key_sorted_priority_queue.sv
// Two-key sorted priority queue: circular entry memory plus control FSM.
// Depends on tksq_pkg.
//
// Usage:
//   Input channel s_*: one beat per operation. s_tuser[1:0] is the mode
//   (insert, remove head, peek head, clear); s_tdata carries the entry.
//   Result channel m_*: exactly one beat per input beat, in order, with the
//   head entry (remove/peek), status flags and the occupancy afterwards.
//   Entries sit in a one-port-read, one-port-write memory used as a ring;
//   removing the head only advances the head pointer.
// Sequence (input beat to m_tvalid): clear, empty and full cases go from
//   idle straight to the result state, remove/peek read the head first, and
//   insert into a non-empty queue walks back from the tail (one memory read per
//   cycle while entries shift up one slot) until the new entry is placed.
// Throughput: one operation at a time; s_tready is high while the control
//   is idle, also while a finished result waits on m_tready.
// Reset (aresetn low, synchronous): queue empty, m_tvalid low. Memory
//   contents are not cleared; only occupied slots are ever read.
// Stall: a result holds on m_* until taken; the next finished result waits
//   in the control until the output register frees up.
`timescale 1ns / 1ps

module two_key_sorted_priority_queue #(
    parameter int CAPACITY = tksq_pkg::DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] priority_class, [27:4] duration, [43:28] entry_tag, [47:44] zero
    input  logic [47:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] head_class, [27:4] head_duration, [43:28] head_tag,
    // [48:44] occupancy, [55:49] zero
    output logic [55:0] m_tdata,
    // [0] head_valid, [2:1] status
    output logic [2:0]  m_tuser
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [AW:0]   CAP_WIDE = (AW + 1)'(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_HEAD = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    // true when stored entry e is served after the new entry n
    function automatic logic goes_after(input tksq_pkg::entry_t e,
                                        input tksq_pkg::entry_t n);
        return (e.cls > n.cls) || ((e.cls == n.cls) && (e.dur < n.dur));
    endfunction

    tksq_pkg::entry_t mem [CAPACITY];
    tksq_pkg::entry_t rd_data_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    tksq_pkg::entry_t mem_wd;
    logic             mem_re;
    logic [AW-1:0]    mem_ra;

    state_t           state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    left_reg, left_next;
    logic             rv_reg, rv_next;
    logic [AW-1:0]    ra_reg, ra_next;
    tksq_pkg::entry_t new_reg, new_next;
    logic [1:0]       op_reg, op_next;
    logic             res_hv_reg, res_hv_next;
    tksq_pkg::entry_t res_entry_reg, res_entry_next;
    logic [1:0]       res_status_reg, res_status_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [55:0]      m_tdata_reg, m_tdata_next;
    logic [2:0]       m_tuser_reg, m_tuser_next;

    tksq_pkg::entry_t in_entry;
    logic [AW:0]      tail_sum;
    logic [AW-1:0]    tail_idx;

    assign in_entry.cls = s_tdata[3:0];
    assign in_entry.dur = s_tdata[27:4];
    assign in_entry.tag = s_tdata[43:28];

    assign tail_sum = (AW + 1)'(head_reg) + (AW + 1)'(count_reg - 1'b1);
    assign tail_idx = (tail_sum >= CAP_WIDE) ? AW'(tail_sum - CAP_WIDE) : AW'(tail_sum);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        left_next       = left_reg;
        rv_next         = 1'b0;
        ra_next         = ra_reg;
        new_next        = new_reg;
        op_next         = op_reg;
        res_hv_next     = res_hv_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_wa          = head_reg;
        mem_wd          = new_reg;
        mem_re          = 1'b0;
        mem_ra          = rd_ptr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_next        = in_entry;
                    op_next         = s_tuser;
                    res_hv_next     = 1'b0;
                    res_entry_next  = '0;
                    res_status_next = tksq_pkg::STATUS_OK;
                    state_next      = ST_RESP;
                    case (s_tuser)
                        tksq_pkg::MODE_INSERT: begin
                            if (count_reg == CAP_CNT) begin
                                res_status_next = tksq_pkg::STATUS_FULL;
                            end else if (count_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_wa     = head_reg;
                                mem_wd     = in_entry;
                                count_next = count_reg + 1'b1;
                            end else begin
                                // start the walk at the tail
                                mem_re      = 1'b1;
                                mem_ra      = tail_idx;
                                rv_next     = 1'b1;
                                ra_next     = tail_idx;
                                rd_ptr_next = ptr_dec(tail_idx);
                                left_next   = count_reg - 1'b1;
                                state_next  = ST_WALK;
                            end
                        end
                        tksq_pkg::MODE_REMOVE, tksq_pkg::MODE_PEEK: begin
                            if (count_reg == '0) begin
                                res_status_next = tksq_pkg::STATUS_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_ra     = head_reg;
                                state_next = ST_HEAD;
                            end
                        end
                        default: begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // keep one read in flight ahead of the compare
                if (left_reg != '0) begin
                    mem_re      = 1'b1;
                    mem_ra      = rd_ptr_reg;
                    rv_next     = 1'b1;
                    ra_next     = rd_ptr_reg;
                    rd_ptr_next = ptr_dec(rd_ptr_reg);
                    left_next   = left_reg - 1'b1;
                end
                if (rv_reg && goes_after(rd_data_reg, new_reg)) begin
                    // shift this entry up one slot
                    mem_we = 1'b1;
                    mem_wa = ptr_inc(ra_reg);
                    mem_wd = rd_data_reg;
                end else begin
                    // place the new entry; drop any read still in flight
                    mem_we     = 1'b1;
                    mem_wa     = rv_reg ? ptr_inc(ra_reg) : head_reg;
                    mem_wd     = new_reg;
                    count_next = count_reg + 1'b1;
                    rv_next    = 1'b0;
                    state_next = ST_RESP;
                end
            end
            ST_HEAD: begin
                res_hv_next    = 1'b1;
                res_entry_next = rd_data_reg;
                if (op_reg == tksq_pkg::MODE_REMOVE) begin
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, tksq_pkg::OCC_W'(count_reg),
                                     res_entry_reg.tag, res_entry_reg.dur,
                                     res_entry_reg.cls};
                    m_tuser_next  = {res_status_reg, res_hv_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            rv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            rv_reg       <= rv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg     <= rd_ptr_next;
        left_reg       <= left_next;
        ra_reg         <= ra_next;
        new_reg        <= new_next;
        op_reg         <= op_next;
        res_hv_reg     <= res_hv_next;
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

>>> design/tksq_checker.sv
// Port-level checker for the two-key sorted priority queue, bound to the top.
// Depends on tksq_pkg and two_key_sorted_priority_queue_defines.svh.
`timescale 1ns / 1ps
`include "two_key_sorted_priority_queue_defines.svh"

module tksq_checker #(
    parameter int CAPACITY = tksq_pkg::DEF_CAPACITY
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic [1:0] status;
    logic [4:0] occ;
    logic       in_beat;

    assign status  = m_tuser[2:1];
    assign occ     = m_tdata[48:44];
    assign in_beat = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]) &&
                     (s_tuser[0] || !s_tuser[0]);

    // a stalled result stays up
    `TKSQ_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // a returned head entry always comes with ok status
    `TKSQ_ASSERT_NOW(a_head_status_ok, aclk, aresetn, m_tvalid && m_tuser[0],
        status == tksq_pkg::STATUS_OK)

    // empty status: no head and nothing queued
    `TKSQ_ASSERT_NOW(a_empty_occ, aclk, aresetn,
        m_tvalid && (status == tksq_pkg::STATUS_EMPTY),
        (occ == 5'd0) && !m_tuser[0])

    // full status only when the queue holds CAPACITY entries
    `TKSQ_ASSERT_NOW(a_full_occ, aclk, aresetn,
        m_tvalid && (status == tksq_pkg::STATUS_FULL),
        (occ == 5'(CAPACITY)) && !m_tuser[0])

    // the result is registered from the response state, so no result shows right after an idle accept
    `TKSQ_ASSERT_NEXT(a_no_instant_result, aclk, aresetn,
        in_beat && !m_tvalid, !m_tvalid)

endmodule

bind two_key_sorted_priority_queue tksq_checker #(.CAPACITY(CAPACITY)) u_tksq_checker (.*);

>>> tb/tksq_result_checker.sv
// Result checker for the two-key sorted priority queue: watches both stream channels,
// keeps a shadow copy of the sorted queue and compares every result beat.
// Depends on tksq_pkg.
`timescale 1ns / 1ps

module tksq_result_checker
    import tksq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          error_count,
    output int          results_pending
);

    typedef struct packed {
        logic               head_valid;
        logic [CLASS_W-1:0] head_class;
        logic [DUR_W-1:0]   head_duration;
        logic [TAG_W-1:0]   head_tag;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } queue_result_t;

    entry_t        shadow_entries [CAPACITY];
    int            shadow_count;
    queue_result_t pending_results [$];
    int            mismatches;

    initial begin
        error_count     = 0;
        results_pending = 0;
        mismatches      = 0;
        shadow_count    = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: result mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Apply one request to the shadow queue and return the result it must produce.
    function automatic queue_result_t serve_request(input logic [1:0] mode, input entry_t req);
        queue_result_t res;
        int            pos;
        int            i;
        res = '0;
        case (mode)
            MODE_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = 0;
                    // skip past smaller classes and equal class with duration not below ours
                    while (pos < shadow_count &&
                           (shadow_entries[pos].cls < req.cls ||
                            (shadow_entries[pos].cls == req.cls &&
                             shadow_entries[pos].dur >= req.dur)))
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = req;
                    shadow_count++;
                end
            end
            MODE_REMOVE, MODE_PEEK: begin
                if (shadow_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.head_valid    = 1'b1;
                    res.head_class    = shadow_entries[0].cls;
                    res.head_duration = shadow_entries[0].dur;
                    res.head_tag      = shadow_entries[0].tag;
                    if (mode == MODE_REMOVE) begin
                        for (i = 1; i < shadow_count; i++)
                            shadow_entries[i-1] = shadow_entries[i];
                        shadow_count--;
                    end
                end
            end
            default: begin
                shadow_count = 0;
            end
        endcase
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            pending_results.delete();
            shadow_count = 0;
        end else begin
            // results always trail their request: compare first
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata[31:0], 0);
                end else begin
                    want = pending_results.pop_front();
                    check_field("head_valid", m_tuser[0], want.head_valid);
                    check_field("status", m_tuser[2:1], want.status);
                    check_field("head_class", m_tdata[3:0], want.head_class);
                    check_field("head_duration", m_tdata[27:4], want.head_duration);
                    check_field("head_tag", m_tdata[43:28], want.head_tag);
                    check_field("occupancy", m_tdata[48:44], want.occupancy);
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(serve_request(s_tuser, entry_t'(s_tdata[43:0])));
        end
        error_count     <= mismatches;
        results_pending <= pending_results.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top for the two-key sorted priority queue: clock, reset, request stimulus,
// result-side backpressure, watchdog and verdict. Depends on tksq_pkg,
// two_key_sorted_priority_queue and tksq_result_checker.
`timescale 1ns / 1ps

module tb;
    import tksq_pkg::*;

    localparam int RANDOM_REQUESTS = 1800;
    localparam int STALL_LIMIT     = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        steady_flow;
    int          error_count;
    int          results_pending;
    int          idle_cycles;

    two_key_sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tksq_result_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // result-side backpressure
    always @(posedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 11);
    end

    // end the run if no beat moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic push_request(input logic [1:0] mode, input logic [3:0] cls,
                                input logic [23:0] dur, input logic [15:0] tag);
        while (!steady_flow && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, tag, dur, cls};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the sender until every result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // narrow ranges often, to force exact ties on both keys
    function automatic logic [3:0] pick_class();
        return $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
    endfunction

    function automatic logic [23:0] pick_duration();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 3));
            1: return 24'hFFFFFF - 24'($urandom_range(0, 2));
            default: return 24'($urandom());
        endcase
    endfunction

    initial begin
        int         sent;
        int         phase_len;
        int         fill_pct;
        int         roll;
        logic [1:0] mode;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= MODE_INSERT;
        m_tready    <= 1'b0;
        steady_flow <= 1'b0;
        idle_cycles <= 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queue, key extremes, ties, clear
        push_request(MODE_REMOVE, 4'd0, 24'd0, 16'd0);
        push_request(MODE_PEEK, 4'd15, 24'hFFFFFF, 16'hFFFF);
        push_request(MODE_INSERT, 4'd15, 24'd0, 16'h0000);
        push_request(MODE_INSERT, 4'd0, 24'hFFFFFF, 16'hFFFF);
        push_request(MODE_INSERT, 4'd0, 24'hFFFFFF, 16'h1234);
        push_request(MODE_INSERT, 4'd0, 24'd0, 16'h0005);
        push_request(MODE_INSERT, 4'd15, 24'hFFFFFF, 16'hA5A5);
        push_request(MODE_PEEK, 4'd0, 24'd0, 16'd0);
        push_request(MODE_REMOVE, 4'd0, 24'd0, 16'd0);
        push_request(MODE_REMOVE, 4'd0, 24'd0, 16'd0);
        push_request(MODE_PEEK, 4'd0, 24'd0, 16'd0);
        push_request(MODE_CLEAR, 4'd7, 24'h5A5A5A, 16'h5A5A);
        push_request(MODE_PEEK, 4'd0, 24'd0, 16'd0);
        push_request(MODE_CLEAR, 4'd0, 24'd0, 16'd0);
        push_request(MODE_INSERT, 4'd8, 24'h800000, 16'h8000);
        push_request(MODE_REMOVE, 4'd0, 24'd0, 16'd0);
        push_request(MODE_REMOVE, 4'd0, 24'd0, 16'd0);
        wait_drained();

        // random: phases that fill, churn or drain the queue
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: fill_pct = 85;
                1: fill_pct = 50;
                default: fill_pct = 20;
            endcase
            repeat (phase_len) begin
                steady_flow <= (sent >= 700 && sent < 1000);
                roll = $urandom_range(0, 99);
                if (roll < fill_pct)
                    mode = MODE_INSERT;
                else if (roll == 99)
                    mode = MODE_CLEAR;
                else if (roll[0])
                    mode = MODE_REMOVE;
                else
                    mode = MODE_PEEK;
                push_request(mode, pick_class(), pick_duration(), 16'($urandom()));
                sent++;
                if (sent % 600 == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
